// ===== rtl/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg
// Shared types, constants and helpers for the integer to radix digits unit.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int MAX_DIGITS_DEF = 31;
  localparam int VALUE_BITS_DEF = 31;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int COUNT_W = 5;

  localparam logic [RADIX_W-1:0] MIN_RADIX     = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX     = 6'd36;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR     = 7'd48;
  localparam logic [CHAR_W-1:0]  LETTER_BASE   = 7'd65;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_SEND,
    ST_ERR
  } state_t;

  // ASCII for a digit value: '0'..'9', then 'A' onward
  function automatic logic [CHAR_W-1:0] digit_char_f(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = ZERO_CHAR + {1'b0, d};
    end else begin
      c = LETTER_BASE + {1'b0, d - DECIMAL_LIMIT};
    end
    return c;
  endfunction

endpackage

// ===== rtl/integer_to_radix_digits_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a non-negative integer into base 2..36 digits, most significant first.
// ----------------------------------------------------------------------------
// Sequence: accept, then each digit on the shared restoring divider, then
//   per digit a read of the store and a load of the output register.
// Items: a new item is not taken until the current one is finished. in_stall
//   stays high from accept until the last result of the item is in the
//   output register.
// Reset: rst_n (sync, active low) clears the sequencer and out_valid only.
module integer_to_radix_digits_unit #(
  parameter int MAX_DIGITS = i2rd_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [VALUE_BITS-1:0]            in_value,
  input  logic [i2rd_pkg::RADIX_W-1:0]     in_radix,
  // result item channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [i2rd_pkg::DIGIT_W-1:0]     out_digit_value,
  output logic [i2rd_pkg::CHAR_W-1:0]      out_digit_char,
  output logic [i2rd_pkg::COUNT_W-1:0]     out_digit_count,
  output logic                             out_bad_radix,
  output logic                             out_last
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);  // holds the digit count itself
  localparam int IDX_W = $clog2(MAX_DIGITS);      // addresses the digit store
  localparam int BIT_W = $clog2(VALUE_BITS);      // divider bit counter

  // sequencer
  i2rd_pkg::state_t state_r, state_nxt;

  // divider datapath: dvd_r shifts the dividend out and the quotient in
  logic [i2rd_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [VALUE_BITS-1:0]        dvd_r, dvd_nxt;
  logic [i2rd_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [BIT_W-1:0]             bit_r, bit_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;

  // digit store, remainders least significant first
  logic [i2rd_pkg::DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [i2rd_pkg::DIGIT_W-1:0] rd_data_r;
  logic                         wr_en;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [i2rd_pkg::DIGIT_W-1:0]  out_value_r, out_value_nxt;
  logic [i2rd_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [i2rd_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                          out_bad_r, out_bad_nxt;
  logic                          out_last_r, out_last_nxt;

  // one restoring-division step
  logic [i2rd_pkg::DIGIT_W:0]   trial;
  logic [i2rd_pkg::DIGIT_W:0]   diff;
  logic                         ge;
  logic [i2rd_pkg::DIGIT_W-1:0] rem_step;
  logic [VALUE_BITS-1:0]        dvd_step;
  logic                         bit_last;
  logic [CNT_W-1:0]             cnt_inc;
  logic                         radix_ok;
  logic                         out_free;

  assign trial    = {rem_r, dvd_r[VALUE_BITS-1]};
  assign ge       = (trial >= {1'b0, radix_r});
  assign diff     = trial - {1'b0, radix_r};
  // remainder stays below radix (< 64), so the top bit drops off either way
  assign rem_step = ge ? diff[i2rd_pkg::DIGIT_W-1:0] : trial[i2rd_pkg::DIGIT_W-1:0];
  assign dvd_step = {dvd_r[VALUE_BITS-2:0], ge};
  assign bit_last = (bit_r == BIT_W'(VALUE_BITS - 1));
  assign cnt_inc  = cnt_r + 1'b1;

  assign radix_ok = (in_radix >= i2rd_pkg::MIN_RADIX) && (in_radix <= i2rd_pkg::MAX_RADIX);
  assign out_free = !out_valid_r || !out_stall;

  assign wr_en = (state_r == i2rd_pkg::ST_DIV) && bit_last;

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_char_nxt  = out_char_r;
    out_count_nxt = out_count_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      i2rd_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (radix_ok) begin
            radix_nxt = in_radix;
            dvd_nxt   = in_value;
            rem_nxt   = '0;
            bit_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = i2rd_pkg::ST_DIV;
          end else begin
            state_nxt = i2rd_pkg::ST_ERR;
          end
        end
      end

      i2rd_pkg::ST_DIV: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_step;
        bit_nxt = bit_r + 1'b1;
        if (bit_last) begin
          // digit done: remainder goes to the store, quotient divides again unless it is zero or the store is full
          cnt_nxt = cnt_inc;
          bit_nxt = '0;
          rem_nxt = '0;
          if ((dvd_step == '0) || (cnt_inc == CNT_W'(MAX_DIGITS))) begin
            idx_nxt   = cnt_r[IDX_W-1:0];  // most significant digit
            state_nxt = i2rd_pkg::ST_FETCH;
          end
        end
      end

      i2rd_pkg::ST_FETCH: begin
        // store read is registered; data shows up in rd_data_r next cycle
        state_nxt = i2rd_pkg::ST_SEND;
      end

      i2rd_pkg::ST_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_data_r;
          out_char_nxt  = i2rd_pkg::digit_char_f(rd_data_r);
          out_count_nxt = i2rd_pkg::COUNT_W'(cnt_r);
          out_bad_nxt   = 1'b0;
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = i2rd_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = i2rd_pkg::ST_FETCH;
          end
        end
      end

      i2rd_pkg::ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_char_nxt  = '0;
          out_count_nxt = '0;
          out_bad_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = i2rd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = i2rd_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2rd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    radix_r     <= radix_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    out_value_r <= out_value_nxt;
    out_char_r  <= out_char_nxt;
    out_count_r <= out_count_nxt;
    out_bad_r   <= out_bad_nxt;
    out_last_r  <= out_last_nxt;
  end

  // digit store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= rem_step;
    end
    rd_data_r <= mem[idx_r];
  end

  assign in_stall        = (state_r != i2rd_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digit_value = out_value_r;
  assign out_digit_char  = out_char_r;
  assign out_digit_count = out_count_r;
  assign out_bad_radix   = out_bad_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/i2rd_checker.sv =====
// ----------------------------------------------------------------------------
// i2rd_checker
// Port-level checks for the integer to radix digits unit, bound to the top.
// ----------------------------------------------------------------------------
module i2rd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [i2rd_pkg::DIGIT_W-1:0] out_digit_value,
  input logic [i2rd_pkg::CHAR_W-1:0]  out_digit_char,
  input logic [i2rd_pkg::COUNT_W-1:0] out_digit_count,
  input logic                         out_bad_radix,
  input logic                         out_last
);

  // a waiting result item is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before item finished");

  // error item is a single, empty, final result
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_radix |->
      out_last && out_digit_count == '0 && out_digit_value == '0 && out_digit_char == '0)
    else $error("malformed bad radix item");

  // character matches digit value
  a_char_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_radix |->
      (out_digit_value < i2rd_pkg::DECIMAL_LIMIT &&
       out_digit_char == i2rd_pkg::ZERO_CHAR + {1'b0, out_digit_value}) ||
      (out_digit_value >= i2rd_pkg::DECIMAL_LIMIT &&
       out_digit_value < i2rd_pkg::MAX_RADIX &&
       out_digit_char == i2rd_pkg::LETTER_BASE +
         {1'b0, out_digit_value - i2rd_pkg::DECIMAL_LIMIT}))
    else $error("digit character does not match digit value");

endmodule

bind integer_to_radix_digits_unit i2rd_checker u_i2rd_checker (.*);
